>>> rtl/rss_pkg.sv
// ============================================================================
// rss_pkg - shared types for the running sample statistics block
// Holds the output field width and the operation codes of the shared adder.
// ============================================================================
package rss_pkg;

    // Width of the multi-bit result fields on the output channel.
    localparam int OUT_W = 16;

    // Operation of the shared wide adder.
    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

endpackage

>>> rtl/running_sample_statistics_top.sv
// ============================================================================
// running_sample_statistics_top - running count, mean, deviation, min and max
// Accumulates signed Q8.8 samples and reports the statistics after each beat.
// ============================================================================
//
// Usage: the input channel (i_valid, o_stall) carries one sample and a start
// flag per beat. A set start flag clears the statistics before the sample is
// added. Every input beat produces exactly one output beat (o_valid, i_stall)
// with count, mean, sample standard deviation, minimum, maximum, spread and
// the overflow flag. Once the count sits at its limit, samples are dropped
// and the overflow flag stays set until the next start flag.
// Sequencing: one wide adder is shared by every serial pass
// (mean divide, two shift-add multiplies, the n*(n-1) multiply, the variance
// divide and the square root). An item with two or more samples in its set
// runs every pass in that order; a set of one sample runs only the mean
// divide. The result beat is presented in the same cycle as the block is
// ready again. o_stall is high for the whole computation of an item.
// Reset (synchronous, active low) empties the set and drops any result.
// A stalled receiver does not hold up the next item: the result sits in the
// output register while the next item is computed, and the sequencer waits
// in its final state only if that register is still full.
//
module running_sample_statistics_top
    import rss_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_BITS  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Input channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_start_new_set,
    // Output channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic        [OUT_W-1:0]       o_count,
    output logic signed [OUT_W-1:0]       o_mean,
    output logic        [OUT_W-1:0]       o_std_dev,
    output logic signed [OUT_W-1:0]       o_minimum,
    output logic signed [OUT_W-1:0]       o_maximum,
    output logic        [OUT_W-1:0]       o_spread,
    output logic                          o_overflow
);

    // Running sum, sum of squares and the wide product/remainder datapath.
    localparam int SB     = SAMPLE_BITS;
    localparam int CB     = COUNT_BITS;
    localparam int SUM_W  = SB + CB;
    localparam int SQ_W   = 2 * SB + CB;
    localparam int P_W    = 2 * SUM_W;
    localparam int QB     = 2 * SB;
    localparam int MAX_IT = (SUM_W > QB) ? SUM_W : QB;
    localparam int STEP_W = $clog2(MAX_IT);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ACC,
        S_SETUP,
        S_MEAN,
        S_MUL_A,
        S_MUL_B,
        S_SUB,
        S_MUL_D,
        S_DIV,
        S_SQRT,
        S_DONE
    } t_state;

    t_state                    r_state;

    // Statistics of the current set.
    logic        [CB-1:0]      r_count;
    logic signed [SUM_W-1:0]   r_sum;
    logic        [SQ_W-1:0]    r_sumsq;
    logic signed [SB-1:0]      r_min;
    logic signed [SB-1:0]      r_max;
    logic                      r_drop;

    // Captured input beat.
    logic signed [SB-1:0]      r_smp;
    logic                      r_start;

    // Sequencer datapath.
    logic        [P_W-1:0]     r_acc;
    logic        [P_W-1:0]     r_mcand;
    logic        [SUM_W-1:0]   r_mplier;
    logic        [P_W-1:0]     r_prod_a;
    logic        [QB-1:0]      r_quo;
    logic        [STEP_W-1:0]  r_step;
    logic        [SB-1:0]      r_mean;
    logic        [SB-1:0]      r_sd;

    // Output register.
    logic                      r_out_valid;
    logic        [OUT_W-1:0]   r_out_count;
    logic        [OUT_W-1:0]   r_out_mean;
    logic        [OUT_W-1:0]   r_out_sd;
    logic        [OUT_W-1:0]   r_out_min;
    logic        [OUT_W-1:0]   r_out_max;
    logic        [OUT_W-1:0]   r_out_spread;
    logic                      r_out_ovf;

    // ------------------------------------------------------------------
    // Accumulate: applies the start flag, then adds the sample to the set, or drops it when the set is full.
    // ------------------------------------------------------------------
    logic        [CB-1:0]      b_count;
    logic signed [SUM_W-1:0]   b_sum;
    logic        [SQ_W-1:0]    b_sumsq;
    logic signed [SB-1:0]      b_min;
    logic signed [SB-1:0]      b_max;
    logic                      b_drop;
    logic                      set_full;
    logic                      set_empty;
    logic        [SB-1:0]      smp_mag;
    logic        [QB-1:0]      smp_sq;
    logic        [CB-1:0]      n_count;
    logic signed [SUM_W-1:0]   n_sum;
    logic        [SQ_W-1:0]    n_sumsq;
    logic signed [SB-1:0]      n_min;
    logic signed [SB-1:0]      n_max;
    logic                      n_drop;

    assign b_count   = r_start ? '0 : r_count;
    assign b_sum     = r_start ? '0 : r_sum;
    assign b_sumsq   = r_start ? '0 : r_sumsq;
    assign b_min     = r_start ? '0 : r_min;
    assign b_max     = r_start ? '0 : r_max;
    assign b_drop    = r_start ? 1'b0 : r_drop;
    assign set_full  = &b_count;
    assign set_empty = (b_count == '0);
    assign smp_mag   = r_smp[SB-1] ? $unsigned(~r_smp + 1'b1) : $unsigned(r_smp);
    assign smp_sq    = smp_mag * smp_mag;

    always_comb begin
        n_count = b_count;
        n_sum   = b_sum;
        n_sumsq = b_sumsq;
        n_min   = b_min;
        n_max   = b_max;
        n_drop  = b_drop;
        if (set_full) begin
            n_drop = 1'b1;
        end else begin
            n_count = b_count + CB'(1);
            n_sum   = b_sum + SUM_W'(r_smp);
            n_sumsq = b_sumsq + SQ_W'(smp_sq);
            if (set_empty || (r_smp < b_min)) begin
                n_min = r_smp;
            end
            if (set_empty || (r_smp > b_max)) begin
                n_max = r_smp;
            end
        end
    end

    // Magnitude of the running sum, used by the mean divide and the square.
    logic [SUM_W-1:0] sum_abs;
    assign sum_abs = r_sum[SUM_W-1] ? $unsigned(-r_sum) : $unsigned(r_sum);

    // ------------------------------------------------------------------
    // Shared wide adder. Subtraction reports "no borrow" in the carry bit.
    // ------------------------------------------------------------------
    t_alu_op          alu_op;
    logic [P_W-1:0]   alu_a;
    logic [P_W-1:0]   alu_b;
    logic [P_W:0]     alu_sum;
    logic             alu_ge;
    logic [P_W-1:0]   alu_res;

    always_comb begin
        alu_op = ALU_ADD;
        alu_a  = r_acc;
        alu_b  = r_mcand;
        case (r_state)
            S_MEAN, S_DIV: begin
                alu_op = ALU_SUB;
            end
            S_SQRT: begin
                alu_op = ALU_SUB;
                alu_b  = r_mcand | P_W'(r_quo);
            end
            S_SUB: begin
                alu_op = ALU_SUB;
                alu_a  = r_prod_a;
                alu_b  = r_acc;
            end
            default: begin
                alu_op = ALU_ADD;
            end
        endcase
    end

    assign alu_sum = {1'b0, alu_a}
                   + {1'b0, (alu_op == ALU_SUB) ? ~alu_b : alu_b}
                   + (P_W+1)'(alu_op == ALU_SUB);
    assign alu_ge  = alu_sum[P_W];
    assign alu_res = alu_sum[P_W-1:0];

    // Shift-add step: the multiplicand is added when the multiplier bit is set.
    logic [P_W-1:0] mul_acc;
    assign mul_acc = r_mplier[0] ? alu_res : r_acc;

    // Restoring divide step: one quotient bit per cycle.
    logic [QB-1:0] div_quo;
    assign div_quo = {r_quo[QB-2:0], alu_ge};

    // Square root step: next partial root.
    logic [P_W-1:0] root_next;
    assign root_next = alu_ge ? ((r_mcand >> 1) | P_W'(r_quo)) : (r_mcand >> 1);

    logic [SB-1:0] mean_mag;
    assign mean_mag = div_quo[SB-1:0];

    logic last_step;
    assign last_step = (r_step == '0);

    // ------------------------------------------------------------------
    // Output field formatting.
    // ------------------------------------------------------------------
    logic [CB+OUT_W-1:0]  cnt_wide;
    logic [SB+OUT_W-1:0]  mean_wide;
    logic [SB+OUT_W-1:0]  sd_wide;
    logic [SB+OUT_W-1:0]  min_wide;
    logic [SB+OUT_W-1:0]  max_wide;
    logic [SB:0]          spread_full;
    logic [SB+OUT_W-1:0]  spread_wide;
    logic [OUT_W-1:0]     sd_out;

    assign cnt_wide    = {{OUT_W{1'b0}}, r_count};
    assign mean_wide   = {{OUT_W{r_mean[SB-1]}}, r_mean};
    assign sd_wide     = {{OUT_W{1'b0}}, r_sd};
    assign min_wide    = {{OUT_W{r_min[SB-1]}}, r_min};
    assign max_wide    = {{OUT_W{r_max[SB-1]}}, r_max};
    assign spread_full = {r_max[SB-1], r_max} - {r_min[SB-1], r_min};
    assign spread_wide = {{OUT_W{1'b0}}, spread_full[SB-1:0]};
    // A root wider than the field saturates.
    assign sd_out      = (|sd_wide[SB+OUT_W-1:OUT_W]) ? '1 : sd_wide[OUT_W-1:0];

    // ------------------------------------------------------------------
    // Sequencer and registered outputs.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_sum       <= '0;
            r_sumsq     <= '0;
            r_min       <= '0;
            r_max       <= '0;
            r_drop      <= 1'b0;
        end else begin
            // The final state reloads the output register itself.
            if (r_out_valid && !i_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_smp   <= i_sample;
                        r_start <= i_start_new_set;
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    r_count <= n_count;
                    r_sum   <= n_sum;
                    r_sumsq <= n_sumsq;
                    r_min   <= n_min;
                    r_max   <= n_max;
                    r_drop  <= n_drop;
                    r_state <= S_SETUP;
                end
                S_SETUP: begin
                    r_acc   <= P_W'(sum_abs);
                    r_mcand <= P_W'(r_count) << (SB - 1);
                    r_quo   <= '0;
                    r_step  <= STEP_W'(SB - 1);
                    if (r_count == '0) begin
                        r_mean  <= '0;
                        r_sd    <= '0;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_MEAN;
                    end
                end
                S_MEAN: begin
                    if (last_step) begin
                        r_mean <= r_sum[SUM_W-1] ? (~mean_mag + 1'b1) : mean_mag;
                        if (r_count[CB-1:1] == '0) begin
                            // Fewer than two samples: no deviation.
                            r_sd    <= '0;
                            r_state <= S_DONE;
                        end else begin
                            r_acc    <= '0;
                            r_mcand  <= P_W'(r_sumsq);
                            r_mplier <= SUM_W'(r_count);
                            r_step   <= STEP_W'(CB - 1);
                            r_state  <= S_MUL_A;
                        end
                    end else begin
                        if (alu_ge) begin
                            r_acc <= alu_res;
                        end
                        r_quo   <= div_quo;
                        r_mcand <= r_mcand >> 1;
                        r_step  <= r_step - STEP_W'(1);
                    end
                end
                S_MUL_A: begin
                    if (last_step) begin
                        r_prod_a <= mul_acc;
                        r_acc    <= '0;
                        r_mcand  <= P_W'(sum_abs);
                        r_mplier <= sum_abs;
                        r_step   <= STEP_W'(SUM_W - 1);
                        r_state  <= S_MUL_B;
                    end else begin
                        r_acc    <= mul_acc;
                        r_mcand  <= r_mcand << 1;
                        r_mplier <= r_mplier >> 1;
                        r_step   <= r_step - STEP_W'(1);
                    end
                end
                S_MUL_B: begin
                    r_acc    <= mul_acc;
                    r_mcand  <= r_mcand << 1;
                    r_mplier <= r_mplier >> 1;
                    r_step   <= r_step - STEP_W'(1);
                    if (last_step) begin
                        r_state <= S_SUB;
                    end
                end
                S_SUB: begin
                    if (alu_ge) begin
                        r_prod_a <= alu_res;
                        r_acc    <= '0;
                        r_mcand  <= P_W'(r_count);
                        r_mplier <= SUM_W'(r_count - CB'(1));
                        r_step   <= STEP_W'(CB - 1);
                        r_state  <= S_MUL_D;
                    end else begin
                        // Negative numerator: deviation reported as zero.
                        r_sd    <= '0;
                        r_state <= S_DONE;
                    end
                end
                S_MUL_D: begin
                    if (last_step) begin
                        r_acc   <= r_prod_a;
                        r_mcand <= mul_acc << (QB - 1);
                        r_quo   <= '0;
                        r_step  <= STEP_W'(QB - 1);
                        r_state <= S_DIV;
                    end else begin
                        r_acc    <= mul_acc;
                        r_mcand  <= r_mcand << 1;
                        r_mplier <= r_mplier >> 1;
                        r_step   <= r_step - STEP_W'(1);
                    end
                end
                S_DIV: begin
                    if (last_step) begin
                        r_acc   <= P_W'(div_quo);
                        r_mcand <= '0;
                        r_quo   <= QB'(1) << (QB - 2);
                        r_step  <= STEP_W'(SB - 1);
                        r_state <= S_SQRT;
                    end else begin
                        if (alu_ge) begin
                            r_acc <= alu_res;
                        end
                        r_quo   <= div_quo;
                        r_mcand <= r_mcand >> 1;
                        r_step  <= r_step - STEP_W'(1);
                    end
                end
                S_SQRT: begin
                    if (alu_ge) begin
                        r_acc <= alu_res;
                    end
                    r_mcand <= root_next;
                    r_quo   <= r_quo >> 2;
                    r_step  <= r_step - STEP_W'(1);
                    if (last_step) begin
                        r_sd    <= root_next[SB-1:0];
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || !i_stall) begin
                        r_out_valid  <= 1'b1;
                        r_out_count  <= cnt_wide[OUT_W-1:0];
                        r_out_mean   <= mean_wide[OUT_W-1:0];
                        r_out_sd     <= sd_out;
                        r_out_min    <= min_wide[OUT_W-1:0];
                        r_out_max    <= max_wide[OUT_W-1:0];
                        r_out_spread <= spread_wide[OUT_W-1:0];
                        r_out_ovf    <= r_drop;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall    = (r_state != S_IDLE);
    assign o_valid    = r_out_valid;
    assign o_count    = r_out_count;
    assign o_mean     = r_out_mean;
    assign o_std_dev  = r_out_sd;
    assign o_minimum  = r_out_min;
    assign o_maximum  = r_out_max;
    assign o_spread   = r_out_spread;
    assign o_overflow = r_out_ovf;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("block accepted a beat and was not busy afterwards");

    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) |-> (r_min <= r_max))
        else $error("set minimum exceeds set maximum");

    a_drop_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drop |-> (&r_count))
        else $error("overflow flag set while the count is below its limit");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result loaded outside the final sequencer state");

    a_root_needs_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQRT) |-> (r_count[CB-1:1] != '0))
        else $error("square root pass entered with fewer than two samples");

endmodule
